// ===== src/pdc_pkg.sv =====
package pdc_pkg;

   // Delay line depth, default
   localparam int DELAY_DEPTH_DEF = 8;

   // Field widths
   localparam int POS_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 15;
   localparam int ZONE_W  = 14;
   localparam int DELAY_W = 3;
   localparam int DRIVE_W = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Internal arithmetic widths
   localparam int ERR_W   = 17;  // target - measured
   localparam int DIFF_W  = 18;  // error difference
   localparam int PROP_W  = 34;  // 17b unsigned-as-signed x 17b
   localparam int DERIV_W = 35;  // 17b x 18b
   localparam int SUM_W   = 40;
   localparam int FRAC_SHIFT = 10;
   localparam int RAW_W   = SUM_W - FRAC_SHIFT;
   localparam int LIM_W   = 17;  // signed limit
   localparam int CMP_W   = 18;  // signed position compares

   // Zone drive limits, Q7.8 volts
   localparam logic signed [LIM_W-1:0] LIM_CRAWL     = 17'sd512;
   localparam logic signed [LIM_W-1:0] LIM_SLOW      = 17'sd1536;
   localparam logic signed [LIM_W-1:0] LIM_CRAWL_NEG = -17'sd512;
   localparam logic signed [LIM_W-1:0] LIM_SLOW_NEG  = -17'sd1536;

   // Register reset values
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd4096;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd3413;
   localparam logic [DELAY_W-1:0] RESP_DELAY_RST = 3'd0;
   localparam logic [LIMIT_W-1:0] FULL_LIMIT_RST = 15'd7680;
   localparam logic [POS_W-1:0]   MIN_POS_RST    = 16'd14784;
   localparam logic [POS_W-1:0]   MAX_POS_RST    = 16'd34624;
   localparam logic [ZONE_W-1:0]  SLOW_ZONE_RST  = 14'd1920;
   localparam logic [ZONE_W-1:0]  CRAWL_ZONE_RST = 14'd320;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_DERIV_GAIN = 3'd1,
      CSR_RESP_DELAY = 3'd2,
      CSR_FULL_LIMIT = 3'd3,
      CSR_MIN_POS    = 3'd4,
      CSR_MAX_POS    = 3'd5,
      CSR_SLOW_ZONE  = 3'd6,
      CSR_CRAWL_ZONE = 3'd7
   } csr_index_type;

endpackage

// ===== src/pd_position_controller.sv =====
// PD position controller with position-dependent drive saturation.
//
// Request channel (req_valid/req_ready): one transaction per control tick,
// carrying target and measured position, unsigned Q10.6.
// Response channel (rsp_valid/rsp_ready): one transaction per request,
// carrying the clipped drive (signed Q7.8 volts) and a saturated flag.
// Register port (csr_write_en/csr_index/csr_wdata): single-cycle writes,
// no read-back; write only while no transaction is in flight.
//
// Two register stages. The input register takes the error and the
// chosen delay-line taps; gain products, sum, zone limits and clip sit
// between it and the output register, which drives the response channel.
// Throughput: one transaction per cycle, back to back, while rsp_ready stays high.
// A stalled response holds the output register; the input register still
// fills, and req_ready falls only once both stages are occupied.
// Reset: synchronous, clears both stages, both delay lines and loads the
// register defaults.
module pd_position_controller #(
   parameter int DELAY_DEPTH = pdc_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pdc_pkg::POS_W-1:0]             req_target_pos,
   input  logic [pdc_pkg::POS_W-1:0]             req_measured_pos,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pdc_pkg::DRIVE_W-1:0]    rsp_drive_voltage,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_en,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pdc_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int TAP_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

   // ---------------- configuration registers ----------------
   logic [pdc_pkg::GAIN_W-1:0]  prop_gain_ff;
   logic [pdc_pkg::GAIN_W-1:0]  deriv_gain_ff;
   logic [pdc_pkg::DELAY_W-1:0] resp_delay_ff;
   logic [pdc_pkg::LIMIT_W-1:0] full_limit_ff;
   logic [pdc_pkg::POS_W-1:0]   min_pos_ff;
   logic [pdc_pkg::POS_W-1:0]   max_pos_ff;
   logic [pdc_pkg::ZONE_W-1:0]  slow_zone_ff;
   logic [pdc_pkg::ZONE_W-1:0]  crawl_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= pdc_pkg::PROP_GAIN_RST;
         deriv_gain_ff <= pdc_pkg::DERIV_GAIN_RST;
         resp_delay_ff <= pdc_pkg::RESP_DELAY_RST;
         full_limit_ff <= pdc_pkg::FULL_LIMIT_RST;
         min_pos_ff    <= pdc_pkg::MIN_POS_RST;
         max_pos_ff    <= pdc_pkg::MAX_POS_RST;
         slow_zone_ff  <= pdc_pkg::SLOW_ZONE_RST;
         crawl_zone_ff <= pdc_pkg::CRAWL_ZONE_RST;
      end else if (csr_write_en) begin
         // Data is truncated to the register width
         case (pdc_pkg::csr_index_type'(csr_index))
            pdc_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[pdc_pkg::GAIN_W-1:0];
            pdc_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata[pdc_pkg::GAIN_W-1:0];
            pdc_pkg::CSR_RESP_DELAY: resp_delay_ff <= csr_wdata[pdc_pkg::DELAY_W-1:0];
            pdc_pkg::CSR_FULL_LIMIT: full_limit_ff <= csr_wdata[pdc_pkg::LIMIT_W-1:0];
            pdc_pkg::CSR_MIN_POS:    min_pos_ff    <= csr_wdata[pdc_pkg::POS_W-1:0];
            pdc_pkg::CSR_MAX_POS:    max_pos_ff    <= csr_wdata[pdc_pkg::POS_W-1:0];
            pdc_pkg::CSR_SLOW_ZONE:  slow_zone_ff  <= csr_wdata[pdc_pkg::ZONE_W-1:0];
            pdc_pkg::CSR_CRAWL_ZONE: crawl_zone_ff <= csr_wdata[pdc_pkg::ZONE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff;
   logic adv1, adv2, accept;

   // A stage may load when it is empty or its contents move on
   assign adv2      = !s2_valid_ff || rsp_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign accept    = req_valid && adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------- stage 1: error, delay lines, tap select ----------------
   // err_hist_ff[k] is the sample that becomes tap k once this tick's sample
   // is shifted in; tap 0 is the current sample itself.
   logic signed [pdc_pkg::ERR_W-1:0]  err_hist_ff  [1:DELAY_DEPTH-1];
   logic signed [pdc_pkg::DIFF_W-1:0] diff_hist_ff [1:DELAY_DEPTH-1];

   logic signed [pdc_pkg::ERR_W-1:0]  cur_err;
   logic signed [pdc_pkg::DIFF_W-1:0] cur_diff;
   logic [TAP_W-1:0]                  tap;
   logic signed [pdc_pkg::ERR_W-1:0]  sel_err_in;
   logic signed [pdc_pkg::DIFF_W-1:0] sel_diff_in;

   assign cur_err  = $signed({1'b0, req_target_pos}) - $signed({1'b0, req_measured_pos});
   assign cur_diff = $signed({cur_err[pdc_pkg::ERR_W-1], cur_err})
                   - $signed({err_hist_ff[1][pdc_pkg::ERR_W-1], err_hist_ff[1]});

   always_comb begin
      // Tap clamps to the deepest entry
      if (int'(resp_delay_ff) > DELAY_DEPTH - 1) begin
         tap = TAP_W'(DELAY_DEPTH - 1);
      end else begin
         tap = TAP_W'(resp_delay_ff);
      end
      sel_err_in  = cur_err;
      sel_diff_in = cur_diff;
      for (int j = 1; j < DELAY_DEPTH; j++) begin
         if (tap == TAP_W'(j)) begin
            sel_err_in  = err_hist_ff[j];
            sel_diff_in = diff_hist_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j < DELAY_DEPTH; j++) begin
            err_hist_ff[j]  <= '0;
            diff_hist_ff[j] <= '0;
         end
      end else if (accept) begin
         err_hist_ff[1]  <= cur_err;
         diff_hist_ff[1] <= cur_diff;
         for (int j = 2; j < DELAY_DEPTH; j++) begin
            err_hist_ff[j]  <= err_hist_ff[j-1];
            diff_hist_ff[j] <= diff_hist_ff[j-1];
         end
      end
   end

   logic signed [pdc_pkg::ERR_W-1:0]  s1_err_ff;
   logic signed [pdc_pkg::DIFF_W-1:0] s1_diff_ff;
   logic [pdc_pkg::POS_W-1:0]         s1_pos_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff  <= sel_err_in;
         s1_diff_ff <= sel_diff_in;
         s1_pos_ff  <= req_measured_pos;
      end
   end

   // ---------------- stage 2: gain products, zone limits, sum, clip ----------------
   logic signed [pdc_pkg::PROP_W-1:0]  prop_term;
   logic signed [pdc_pkg::DERIV_W-1:0] deriv_term;
   logic signed [pdc_pkg::CMP_W-1:0]   pos_s, hi_crawl, hi_slow, lo_crawl, lo_slow;
   logic signed [pdc_pkg::LIM_W-1:0]   upper_lim, lower_lim, full_pos, full_neg;

   assign prop_term  = $signed({1'b0, prop_gain_ff})  * s1_err_ff;
   assign deriv_term = $signed({1'b0, deriv_gain_ff}) * s1_diff_ff;

   assign pos_s    = $signed({2'b00, s1_pos_ff});
   assign hi_crawl = $signed({2'b00, max_pos_ff}) - $signed({4'b0000, crawl_zone_ff});
   assign hi_slow  = $signed({2'b00, max_pos_ff}) - $signed({4'b0000, slow_zone_ff});
   assign lo_crawl = $signed({2'b00, min_pos_ff}) + $signed({4'b0000, crawl_zone_ff});
   assign lo_slow  = $signed({2'b00, min_pos_ff}) + $signed({4'b0000, slow_zone_ff});
   assign full_pos = $signed({2'b00, full_limit_ff});
   assign full_neg = -full_pos;

   // Each end decided on its own; the crawl zone wins over the slow zone
   always_comb begin
      if (pos_s > hi_crawl) begin
         upper_lim = pdc_pkg::LIM_CRAWL;
      end else if (pos_s > hi_slow) begin
         upper_lim = pdc_pkg::LIM_SLOW;
      end else begin
         upper_lim = full_pos;
      end
      if (pos_s < lo_crawl) begin
         lower_lim = pdc_pkg::LIM_CRAWL_NEG;
      end else if (pos_s < lo_slow) begin
         lower_lim = pdc_pkg::LIM_SLOW_NEG;
      end else begin
         lower_lim = full_neg;
      end
   end

   logic signed [pdc_pkg::SUM_W-1:0] sum;
   logic signed [pdc_pkg::RAW_W-1:0] raw, upper_x, lower_x;
   logic signed [pdc_pkg::DRIVE_W-1:0] drive_in;
   logic                               sat_in;

   // Derivative term carries four fewer fraction bits, hence the shift
   assign sum = $signed({{(pdc_pkg::SUM_W-pdc_pkg::PROP_W){prop_term[pdc_pkg::PROP_W-1]}},
                         prop_term})
              + $signed({{(pdc_pkg::SUM_W-pdc_pkg::DERIV_W-4){deriv_term[pdc_pkg::DERIV_W-1]}},
                         deriv_term, 4'b0000});
   // Dropping the low bits floors toward minus infinity
   assign raw = sum[pdc_pkg::SUM_W-1:pdc_pkg::FRAC_SHIFT];

   assign upper_x = $signed({{(pdc_pkg::RAW_W-pdc_pkg::LIM_W){upper_lim[pdc_pkg::LIM_W-1]}},
                             upper_lim});
   assign lower_x = $signed({{(pdc_pkg::RAW_W-pdc_pkg::LIM_W){lower_lim[pdc_pkg::LIM_W-1]}},
                             lower_lim});

   always_comb begin
      if (raw > upper_x) begin
         drive_in = upper_lim[pdc_pkg::DRIVE_W-1:0];
         sat_in   = 1'b1;
      end else if (raw < lower_x) begin
         drive_in = lower_lim[pdc_pkg::DRIVE_W-1:0];
         sat_in   = 1'b1;
      end else begin
         drive_in = raw[pdc_pkg::DRIVE_W-1:0];
         sat_in   = 1'b0;
      end
   end

   logic signed [pdc_pkg::DRIVE_W-1:0] rsp_drive_ff;
   logic                               rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         rsp_drive_ff <= drive_in;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_drive_voltage = rsp_drive_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

// ===== src/pdc_checker.sv =====
module pdc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pdc_pkg::DRIVE_W-1:0] rsp_drive_voltage,
   input logic                               rsp_saturated
);

   // Nothing left in the output register after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Back-pressure on requests only comes from a stalled response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without response stall");

   // A taken request is followed by rsp_valid once it has passed the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("response missing after request");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_drive_voltage) && $stable(rsp_saturated)))
      else $error("stalled response changed");

endmodule

bind pd_position_controller pdc_checker u_pdc_checker (.*);
